@@ rtl/apjb_pkg.sv @@
// Shared types and constants of the audio playout jitter buffer.
package apjb_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_THRESH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE     = 2'd1;

  localparam logic [5:0] PLAY_THRESH_RST = 6'd10;
  localparam logic [7:0] SILENCE_RST     = 8'd128;

  localparam logic [2:0] OP_RX    = 3'd0;
  localparam logic [2:0] OP_TICK  = 3'd1;
  localparam logic [2:0] OP_LOCAL = 3'd2;
  localparam logic [2:0] OP_PTT   = 3'd3;
  localparam logic [2:0] OP_MUTE  = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] sample;
  } in_item_t;

  typedef struct packed {
    logic       dac_valid;
    logic [7:0] dac_value;
    logic       radio_valid;
    logic [7:0] radio_value;
    logic       dropped;
    logic [5:0] fill_level;
    logic       transmitting;
    logic       muted;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_RX,
    CMD_TICK,
    CMD_LOCAL,
    CMD_PTT,
    CMD_MUTE
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] sample;
  } q_item_t;

  typedef enum logic {
    BK_RUN,
    BK_POP
  } bk_state_t;

endpackage

@@ rtl/apjb_front.sv @@
// Front end: accepts transactions, decodes the op and queues them for the back end.
module apjb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  apjb_pkg::in_item_t in_data,
  output logic               q_valid,
  output apjb_pkg::q_item_t  q_head,
  input  logic               q_pop
);

  logic [1:0]        cnt_r, cnt_nxt;
  logic              wr_r, wr_nxt;
  logic              rd_r, rd_nxt;
  logic              push;
  apjb_pkg::q_item_t item;
  apjb_pkg::q_item_t q_r [2];

  assign busy    = cnt_r[1];
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = q_r[rd_r];

  always_comb begin
    item.sample = in_data.sample;
    unique case (in_data.op)
      apjb_pkg::OP_RX:    item.cmd = apjb_pkg::CMD_RX;
      apjb_pkg::OP_TICK:  item.cmd = apjb_pkg::CMD_TICK;
      apjb_pkg::OP_LOCAL: item.cmd = apjb_pkg::CMD_LOCAL;
      apjb_pkg::OP_PTT:   item.cmd = apjb_pkg::CMD_PTT;
      apjb_pkg::OP_MUTE:  item.cmd = apjb_pkg::CMD_MUTE;
      default:            item.cmd = apjb_pkg::CMD_NOP;
    endcase
  end

  always_comb begin
    wr_nxt  = wr_r ^ push;
    rd_nxt  = rd_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= item;
    end
  end

endmodule

@@ rtl/apjb_back.sv @@
// Back end: ring buffer, playback control and the result register.
module apjb_back #(
  parameter int DEPTH = apjb_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [5:0]          play_thresh,
  input  logic [7:0]          silence_value,
  input  logic                q_valid,
  input  apjb_pkg::q_item_t   q_head,
  output logic                q_pop,
  output logic                out_valid,
  output apjb_pkg::out_item_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = (AW > 6) ? AW : 6;

  apjb_pkg::bk_state_t state_r, state_nxt;
  logic [AW-1:0]       rp_r, rp_nxt;
  logic [AW-1:0]       wp_r, wp_nxt;
  logic [AW-1:0]       count_r, count_nxt;
  logic                ready_r, ready_nxt;
  logic                talk_r, talk_nxt;
  logic                mute_r, mute_nxt;
  logic                out_valid_r, out_valid_nxt;
  apjb_pkg::out_item_t out_r, out_nxt;
  apjb_pkg::out_item_t pend_r, pend_nxt;
  apjb_pkg::out_item_t res;
  logic [7:0]          ring_r [DEPTH];
  logic [7:0]          rd_data_r;
  logic                step;
  logic                rdy;
  logic                full;
  logic                mem_we;
  logic                pop_wait;
  logic [CW-1:0]       lvl_ext;
  logic [CW-1:0]       fill_ext;

  assign step      = (state_r == apjb_pkg::BK_RUN) && q_valid;
  assign q_pop     = step;
  assign full      = (count_r == AW'(DEPTH - 1));
  assign lvl_ext   = CW'(count_r);
  assign fill_ext  = CW'(count_nxt);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      apjb_pkg::BK_RUN: begin
        if (step && pop_wait) begin
          state_nxt = apjb_pkg::BK_POP;
        end
      end
      apjb_pkg::BK_POP: begin
        state_nxt = apjb_pkg::BK_RUN;
      end
      default: begin
        state_nxt = apjb_pkg::BK_RUN;
      end
    endcase
  end

  always_comb begin
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    count_nxt     = count_r;
    ready_nxt     = ready_r;
    talk_nxt      = talk_r;
    mute_nxt      = mute_r;
    mem_we        = 1'b0;
    pop_wait      = 1'b0;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    pend_nxt      = pend_r;
    res           = '0;
    rdy           = ready_r;
    if (count_r == '0) begin
      rdy = 1'b0;
    end else if (lvl_ext > CW'(play_thresh)) begin
      rdy = 1'b1;
    end
    if (step) begin
      ready_nxt = rdy;
      case (q_head.cmd)
        apjb_pkg::CMD_RX: begin
          if (!talk_r) begin
            if (full) begin
              res.dropped = 1'b1;
            end else begin
              mem_we    = 1'b1;
              wp_nxt    = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
        end
        apjb_pkg::CMD_TICK: begin
          res.dac_valid = 1'b1;
          res.dac_value = silence_value;
          if (talk_r) begin
            ready_nxt = 1'b0;
          end else if (rdy && (count_r != '0)) begin
            rp_nxt    = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
            count_nxt = count_r - 1'b1;
            pop_wait  = !mute_r;
          end
        end
        apjb_pkg::CMD_LOCAL: begin
          if (talk_r) begin
            res.radio_valid = 1'b1;
            res.radio_value = q_head.sample;
          end
        end
        apjb_pkg::CMD_PTT: begin
          talk_nxt = q_head.sample[0];
        end
        apjb_pkg::CMD_MUTE: begin
          mute_nxt = !mute_r;
        end
        default: begin
        end
      endcase
      res.fill_level   = fill_ext[5:0];
      res.transmitting = talk_nxt;
      res.muted        = mute_nxt;
      pend_nxt         = res;
      out_nxt          = res;
      out_valid_nxt    = !pop_wait;
    end else if (state_r == apjb_pkg::BK_POP) begin
      out_valid_nxt     = 1'b1;
      out_nxt           = pend_r;
      out_nxt.dac_value = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= apjb_pkg::BK_RUN;
      rp_r        <= '0;
      wp_r        <= '0;
      count_r     <= '0;
      ready_r     <= 1'b0;
      talk_r      <= 1'b0;
      mute_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      count_r     <= count_nxt;
      ready_r     <= ready_nxt;
      talk_r      <= talk_nxt;
      mute_r      <= mute_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_r[wp_r] <= q_head.sample;
    end
    rd_data_r <= ring_r[rp_r];
  end

endmodule

@@ rtl/audio_playout_jitter_buffer_unit.sv @@
// Top level of the audio playout jitter buffer: configuration registers and core.
//
// Input channel: an op and a sample byte on in_data are taken at a rising edge
// with start high and busy low. Ops: radio byte, playback tick, local sample,
// push-to-talk, mute toggle.
// Result channel: every transaction gives one result on out_data, marked by
// out_valid for exactly one cycle; the receiver cannot stall it.
// Configuration: cfg_we, cfg_index, cfg_data write the playback threshold
// (index 0) and silence_value (index 1); write only while idle.
// Results are registered; an unmuted tick that pops a byte passes through
// the BK_POP state first, as the ring memory read is registered.
// Throughput: one transaction per cycle, except that an unmuted pop holds
// the back end in the BK_POP state. A two-entry queue sits between decode and
// the back end; busy rises when it is full.
// Reset: pointers, fill count, ready, talk and mute flags clear, configuration
// returns to a playback threshold of 10 and silence 128. No clearing pass is
// needed.
module audio_playout_jitter_buffer_unit #(
  parameter int DEPTH = apjb_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  apjb_pkg::in_item_t              in_data,
  output logic                            out_valid,
  output apjb_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [apjb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apjb_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [5:0]        play_thresh_r, play_thresh_nxt;
  logic [7:0]        silence_r, silence_nxt;
  logic              q_valid;
  logic              q_pop;
  apjb_pkg::q_item_t q_head;

  always_comb begin
    play_thresh_nxt = play_thresh_r;
    silence_nxt     = silence_r;
    if (cfg_we) begin
      unique case (cfg_index)
        apjb_pkg::CFG_PLAY_THRESH: play_thresh_nxt = cfg_data[5:0];
        apjb_pkg::CFG_SILENCE:     silence_nxt     = cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_thresh_r <= apjb_pkg::PLAY_THRESH_RST;
      silence_r     <= apjb_pkg::SILENCE_RST;
    end else begin
      play_thresh_r <= play_thresh_nxt;
      silence_r     <= silence_nxt;
    end
  end

  apjb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  apjb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .play_thresh   (play_thresh_r),
    .silence_value (silence_r),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_data      (out_data)
  );

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe directly after reset");

  a_one_event_per_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones({out_data.dac_valid, out_data.radio_valid,
                               out_data.dropped}) <= 1))
    else $error("more than one event flagged in one result");

  a_drop_only_receiving: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.dropped) |-> !out_data.transmitting)
    else $error("received byte dropped while transmitting");

  a_radio_only_transmitting: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.radio_valid) |-> out_data.transmitting)
    else $error("local sample forwarded while receiving");

endmodule
